// File: src/mrq_pkg.sv
// Package for the message ring queue: request and status codes, field widths, shared types.
`default_nettype none

package mrq_pkg;

   // Field widths fixed by the request and result formats
   localparam int REQ_TYPE_W = 3;
   localparam int MSG_W      = 32;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;

   // Default storage geometry
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int WORD_WIDTH_DEFAULT  = 32;

   // Capacity register value after reset
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;

   // Request kinds
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_POP        = 3'd0,
      REQ_POST_BACK  = 3'd1,
      REQ_POST_FRONT = 3'd2,
      REQ_PEEK       = 3'd3,
      REQ_FLUSH      = 3'd4
   } req_kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Per-request result info handed from control to the response stage
   typedef struct packed {
      status_type         status;
      logic               from_mem;
      logic [COUNT_W-1:0] count;
   } resp_info_type;

endpackage

`default_nettype wire

// File: src/mrq_ring_mem.sv
// Ring storage: one write port and one registered read port.
`default_nettype none

module mrq_ring_mem #(
   parameter int QUEUE_DEPTH = mrq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int WORD_WIDTH  = mrq_pkg::WORD_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   input  wire logic [WORD_WIDTH-1:0]          wr_data,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   output logic      [WORD_WIDTH-1:0]          rd_data
);

   logic [WORD_WIDTH-1:0] ring_mem [QUEUE_DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   // Write the posted word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   // Read the oldest word, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/mrq_ctrl.sv
// Queue control: capacity register, ring indices, entry count and request decode.
`default_nettype none

module mrq_ctrl #(
   parameter int QUEUE_DEPTH = mrq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wen,
   input  wire logic [mrq_pkg::COUNT_W-1:0]         csr_wdata,
   input  wire logic                                accept,
   input  wire logic [mrq_pkg::REQ_TYPE_W-1:0]      req_type,
   output logic                                     wr_en,
   output logic      [$clog2(QUEUE_DEPTH)-1:0]      wr_addr,
   output logic                                     rd_en,
   output logic      [$clog2(QUEUE_DEPTH)-1:0]      rd_addr,
   output mrq_pkg::resp_info_type                   info,
   output logic      [mrq_pkg::COUNT_W-1:0]         stored_count
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic [mrq_pkg::COUNT_W-1:0] capacity_ff;
   logic [IDX_W-1:0]            read_idx_ff, read_idx_in;
   logic [IDX_W-1:0]            write_idx_ff, write_idx_in;
   logic [mrq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [mrq_pkg::COUNT_W-1:0] cap_eff;
   logic [IDX_W-1:0]            read_fwd, read_back, write_fwd;
   logic                        is_empty, is_full;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= mrq_pkg::CAPACITY_RESET;
      end else if (csr_wen) begin
         capacity_ff <= csr_wdata;
      end
   end

   // Clamp capacity into 1..QUEUE_DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = mrq_pkg::COUNT_W'(1);
      end else if (32'(capacity_ff) > QUEUE_DEPTH) begin
         cap_eff = mrq_pkg::COUNT_W'(QUEUE_DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   // Index steps with wrap at the effective capacity
   assign read_fwd  = (32'(read_idx_ff) + 32'd1 >= 32'(cap_eff)) ? '0 : read_idx_ff + 1'b1;
   assign write_fwd = (32'(write_idx_ff) + 32'd1 >= 32'(cap_eff)) ? '0 : write_idx_ff + 1'b1;
   assign read_back = (read_idx_ff == '0) ? IDX_W'(cap_eff - 1'b1) : read_idx_ff - 1'b1;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff >= cap_eff);

   // Decode the request and form next state and memory access
   always_comb begin
      read_idx_in   = read_idx_ff;
      write_idx_in  = write_idx_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = write_idx_ff;
      rd_en         = 1'b0;
      rd_addr       = read_idx_ff;
      info.status   = mrq_pkg::STATUS_OK;
      info.from_mem = 1'b0;
      case (req_type)
         mrq_pkg::REQ_POP: begin
            if (is_empty) begin
               info.status = mrq_pkg::STATUS_EMPTY;
            end else begin
               rd_en         = accept;
               info.from_mem = 1'b1;
               read_idx_in   = read_fwd;
               count_in      = count_ff - 1'b1;
            end
         end
         mrq_pkg::REQ_POST_BACK: begin
            if (is_full) begin
               info.status = mrq_pkg::STATUS_FULL;
            end else begin
               wr_en        = accept;
               write_idx_in = write_fwd;
               count_in     = count_ff + 1'b1;
            end
         end
         mrq_pkg::REQ_POST_FRONT: begin
            if (is_full) begin
               info.status = mrq_pkg::STATUS_FULL;
            end else begin
               wr_en       = accept;
               wr_addr     = read_back;
               read_idx_in = read_back;
               count_in    = count_ff + 1'b1;
            end
         end
         mrq_pkg::REQ_PEEK: begin
            if (is_empty) begin
               info.status = mrq_pkg::STATUS_EMPTY;
            end else begin
               rd_en         = accept;
               info.from_mem = 1'b1;
            end
         end
         mrq_pkg::REQ_FLUSH: begin
            read_idx_in  = '0;
            write_idx_in = '0;
            count_in     = '0;
         end
         default: begin
         end
      endcase
      info.count = count_in;
   end

   // Advance indices and count on each accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         read_idx_ff  <= '0;
         write_idx_ff <= '0;
         count_ff     <= '0;
      end else if (accept) begin
         read_idx_ff  <= read_idx_in;
         write_idx_ff <= write_idx_in;
         count_ff     <= count_in;
      end
   end

   assign stored_count = count_ff;

endmodule

`default_nettype wire

// File: src/mrq_rsp_stage.sv
// Response path: memory-read stage followed by the output register.
`default_nettype none

module mrq_rsp_stage #(
   parameter int WORD_WIDTH = mrq_pkg::WORD_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire mrq_pkg::resp_info_type          info,
   input  wire logic [WORD_WIDTH-1:0]           rd_data,
   input  wire logic                            rsp_tready,
   output logic                                 can_accept,
   output logic                                 stage_valid,
   output logic                                 rsp_tvalid,
   output mrq_pkg::status_type                  rsp_status,
   output logic      [mrq_pkg::MSG_W-1:0]       rsp_msg,
   output logic      [mrq_pkg::COUNT_W-1:0]     rsp_count
);

   logic                        s1_valid_ff, s1_valid_in;
   mrq_pkg::resp_info_type      s1_info_ff;
   logic                        out_valid_ff, out_valid_in;
   mrq_pkg::status_type         out_status_ff;
   logic [mrq_pkg::MSG_W-1:0]   out_msg_ff;
   logic [mrq_pkg::COUNT_W-1:0] out_count_ff;
   logic                        advance;

   // Move the read stage forward when the output register is free or drains
   assign advance     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign can_accept  = !s1_valid_ff || advance;
   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture result info alongside the memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
   end

   // Load the output register; zero the word unless it came from the ring
   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= s1_info_ff.status;
         out_count_ff  <= s1_info_ff.count;
         out_msg_ff    <= s1_info_ff.from_mem ? mrq_pkg::MSG_W'(rd_data) : '0;
      end
   end

   assign stage_valid = s1_valid_ff;
   assign rsp_tvalid  = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_msg     = out_msg_ff;
   assign rsp_count   = out_count_ff;

endmodule

`default_nettype wire

// File: src/message_ring_queue_front_back.sv
// Top level of the message ring queue with front and back posting.
//
// Mailbox queue of message words. Requests arrive on the req_ stream, one
// kind per transfer: pop, post back, post front, peek or flush. Each request
// gives exactly one result transfer on the rsp_ stream with a status, the
// oldest word for a successful pop or peek (zero otherwise) and the entry
// count after the request. csr_wen/csr_wdata write the capacity (0 acts as
// 1, values above QUEUE_DEPTH act as QUEUE_DEPTH); write it only while idle.
//
// A result passes through the synchronous ring read and then the output
// register before rsp_tvalid. Throughput is one request per cycle while
// req_tready is high; the indices and count update at the request transfer,
// so back-to-back requests to the same entry see each other without stalls.
// When the receiver stalls, one result waits in the output register and one
// more in the read stage; req_tready drops only when both are occupied.
// Reset (synchronous) clears the indices and count, sets the capacity to
// 16 and empties both stages; ring contents are not cleared.
`default_nettype none

module message_ring_queue_front_back #(
   parameter int QUEUE_DEPTH = mrq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int WORD_WIDTH  = mrq_pkg::WORD_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] req_type, [34:3] msg_in, [39:35] zero
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [33:2] msg_out, [38:34] entry_count, [39] zero
   output logic      [39:0] rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic [4:0]  csr_wdata
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic                            accept;
   logic [mrq_pkg::REQ_TYPE_W-1:0]  req_type;
   logic [mrq_pkg::MSG_W-1:0]       msg_in;
   logic                            wr_en, rd_en;
   logic [IDX_W-1:0]                wr_addr, rd_addr;
   logic [WORD_WIDTH-1:0]           rd_data;
   mrq_pkg::resp_info_type          info;
   logic [mrq_pkg::COUNT_W-1:0]     stored_count;
   logic                            stage_valid;
   mrq_pkg::status_type             rsp_status;
   logic [mrq_pkg::MSG_W-1:0]       rsp_msg;
   logic [mrq_pkg::COUNT_W-1:0]     rsp_count;

   // Unpack the request
   assign req_type = req_tdata[2:0];
   assign msg_in   = req_tdata[34:3];
   assign accept   = req_tvalid && req_tready;

   mrq_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .req_type    (req_type),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .info        (info),
      .stored_count(stored_count)
   );

   mrq_ring_mem #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_ring_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(WORD_WIDTH'(msg_in)),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   mrq_rsp_stage #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .info       (info),
      .rd_data    (rd_data),
      .rsp_tready (rsp_tready),
      .can_accept (req_tready),
      .stage_valid(stage_valid),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_msg    (rsp_msg),
      .rsp_count  (rsp_count)
   );

   // Pack the result
   assign rsp_tdata = {1'b0, rsp_count, rsp_msg, rsp_status};

   // Flush leaves the queue empty
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      accept && (req_type == mrq_pkg::REQ_FLUSH) |=> stored_count == '0)
      else $error("count not zero after flush");

   // Pop from a non-empty queue removes exactly one word
   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      accept && (req_type == mrq_pkg::REQ_POP) && (stored_count != '0)
      |=> stored_count == $past(stored_count) - 1'b1)
      else $error("pop did not decrement count");

   // An empty status is reported only with a zero count and zero word
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == mrq_pkg::STATUS_EMPTY)
      |-> (rsp_count == '0) && (rsp_msg == '0))
      else $error("empty status with stored words or data");

   // Requests stall only while both response stages are occupied
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> stage_valid && rsp_tvalid && !rsp_tready)
      else $error("request stalled with room in the response path");

endmodule

`default_nettype wire

// File: sim/tb_message_ring_queue_front_back.sv
// Self-checking testbench for the message ring queue with front and back posting.
`timescale 1ns / 100ps

module tb_message_ring_queue_front_back;

   localparam int           RING_SLOTS     = 16;
   localparam int           RANDOM_ITEMS   = 1700;
   localparam int           MAX_WAIT       = 15;
   localparam int           SETTLE_CYCLES  = 4;
   localparam logic [2:0]   REQ_SPARE_LO   = 3'd5;
   localparam logic [2:0]   REQ_SPARE_HI   = 3'd7;
   localparam logic [4:0]   CAP_ZERO       = 5'd0;
   localparam logic [4:0]   CAP_ONE        = 5'd1;
   localparam logic [4:0]   CAP_FULL_DEPTH = 5'd16;
   localparam logic [4:0]   CAP_MAX_CODE   = 5'd31;
   localparam logic [31:0]  WORD_ONES      = 32'hFFFF_FFFF;

   // One predicted result transfer
   typedef struct {
      mrq_pkg::status_type status;
      logic [31:0]         msg;
      logic [4:0]          count;
   } queue_result_type;

   // Ring queue predictor plus the store of results still owed by the block
   class mrq_scoreboard;
      logic [31:0]      ring_words [RING_SLOTS];
      bit               slot_written [RING_SLOTS];
      int unsigned      rd_slot;
      int unsigned      wr_slot;
      int unsigned      word_count;
      logic [4:0]       capacity;
      queue_result_type pending_results [$];
      int               errors;
      int               kind_seen [8];
      int               full_seen;
      int               empty_seen;
      int               results_checked;

      function new();
         rd_slot    = 0;
         wr_slot    = 0;
         word_count = 0;
         capacity   = mrq_pkg::CAPACITY_RESET;
         foreach (slot_written[i]) slot_written[i] = 1'b0;
      endfunction

      function void set_capacity(logic [4:0] value);
         capacity = value;
      endfunction

      // Clamp the register to 1..RING_SLOTS
      function int unsigned eff_capacity();
         if (capacity == 0) return 1;
         if (capacity > RING_SLOTS) return RING_SLOTS;
         return capacity;
      endfunction

      function int unsigned step_fwd(int unsigned slot);
         return (slot + 1 >= eff_capacity()) ? 0 : slot + 1;
      endfunction

      function int unsigned step_back(int unsigned slot);
         return (slot == 0) ? eff_capacity() - 1 : slot - 1;
      endfunction

      // A pop or peek must never land on a slot that was never written
      function bit read_is_safe();
         return word_count == 0 || slot_written[rd_slot];
      endfunction

      function bit is_full();
         return word_count >= eff_capacity();
      endfunction

      // Apply one accepted request and queue the result it owes
      function void predict_request(logic [2:0] kind, logic [31:0] word);
         queue_result_type want;
         int unsigned      cap;
         cap         = eff_capacity();
         want.status = mrq_pkg::STATUS_OK;
         want.msg    = '0;
         kind_seen[kind]++;
         case (kind)
            mrq_pkg::REQ_POP: begin
               if (word_count == 0) begin
                  want.status = mrq_pkg::STATUS_EMPTY;
               end else begin
                  want.msg = ring_words[rd_slot];
                  rd_slot  = step_fwd(rd_slot);
                  word_count--;
               end
            end
            mrq_pkg::REQ_POST_BACK: begin
               if (word_count >= cap) begin
                  want.status = mrq_pkg::STATUS_FULL;
               end else begin
                  ring_words[wr_slot]   = word;
                  slot_written[wr_slot] = 1'b1;
                  wr_slot               = step_fwd(wr_slot);
                  word_count++;
               end
            end
            mrq_pkg::REQ_POST_FRONT: begin
               if (word_count >= cap) begin
                  want.status = mrq_pkg::STATUS_FULL;
               end else begin
                  rd_slot               = step_back(rd_slot);
                  ring_words[rd_slot]   = word;
                  slot_written[rd_slot] = 1'b1;
                  word_count++;
               end
            end
            mrq_pkg::REQ_PEEK: begin
               if (word_count == 0) want.status = mrq_pkg::STATUS_EMPTY;
               else want.msg = ring_words[rd_slot];
            end
            mrq_pkg::REQ_FLUSH: begin
               rd_slot    = 0;
               wr_slot    = 0;
               word_count = 0;
            end
            default: ;
         endcase
         if (want.status == mrq_pkg::STATUS_FULL) full_seen++;
         if (want.status == mrq_pkg::STATUS_EMPTY) empty_seen++;
         want.count = word_count[4:0];
         pending_results.push_back(want);
      endfunction

      // Compare one result transfer against the oldest prediction
      function void check_result(logic [39:0] data);
         queue_result_type want;
         results_checked++;
         if (pending_results.size() == 0) begin
            $error("result with nothing pending: data %h", data);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (data[1:0] !== want.status) begin
            $error("status expected %0d actual %0d", want.status, data[1:0]);
            errors++;
         end
         if (data[33:2] !== want.msg) begin
            $error("msg_out expected %h actual %h", want.msg, data[33:2]);
            errors++;
         end
         if (data[38:34] !== want.count) begin
            $error("entry_count expected %0d actual %0d", want.count, data[38:34]);
            errors++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_wen    = 1'b0;
   logic [4:0]  csr_wdata  = '0;

   mrq_scoreboard board = new();
   bit            req_no_gap;
   bit            rsp_no_stall;
   int            cap_writes;

   message_ring_queue_front_back u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   // Receiver: stall a random number of cycles, then hold ready until a transfer
   initial begin : rsp_side
      int stall;
      forever begin
         stall = rsp_no_stall ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Offer one request after a random gap and hold it until the transfer
   task automatic send_request(input logic [2:0] kind, input logic [31:0] word);
      int gap;
      gap = req_no_gap ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, word, kind};
      do @(posedge clock); while (!req_tready);
      board.predict_request(kind, word);
   endtask

   // Hold off the sender until every owed result has arrived and the pipe is empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [4:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      board.set_capacity(value);
      cap_writes++;
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return WORD_ONES;
         default: return $urandom;
      endcase
   endfunction

   // Draw a request kind; post_pct biases toward filling or draining
   function automatic logic [2:0] random_kind(int post_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return mrq_pkg::REQ_FLUSH;
      if (roll < 5) return 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      roll = $urandom_range(0, 99);
      if (roll < post_pct)
         return ($urandom_range(0, 2) == 0) ? mrq_pkg::REQ_POST_FRONT
                                            : mrq_pkg::REQ_POST_BACK;
      return ($urandom_range(0, 9) < 7) ? mrq_pkg::REQ_POP : mrq_pkg::REQ_PEEK;
   endfunction

   initial begin : main_flow
      int         sent;
      int         phase_len;
      int         post_pct;
      logic [2:0] kind;
      logic [4:0] cap;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue, both word extremes, wrap backwards, spare codes, flush
      send_request(mrq_pkg::REQ_POP, 32'h0);
      send_request(mrq_pkg::REQ_PEEK, 32'h0);
      send_request(mrq_pkg::REQ_POST_BACK, 32'h0);
      send_request(mrq_pkg::REQ_POST_BACK, WORD_ONES);
      send_request(mrq_pkg::REQ_POST_FRONT, 32'h5A5A_A5A5);
      send_request(mrq_pkg::REQ_PEEK, 32'h0);
      send_request(mrq_pkg::REQ_POP, 32'h0);
      send_request(mrq_pkg::REQ_POP, 32'h0);
      send_request(REQ_SPARE_LO, WORD_ONES);
      send_request(REQ_SPARE_HI, 32'h1234_5678);
      send_request(mrq_pkg::REQ_FLUSH, 32'h0);
      send_request(mrq_pkg::REQ_POP, 32'h0);

      // Directed: capacity zero acts as one
      wait_idle();
      write_capacity(CAP_ZERO);
      send_request(mrq_pkg::REQ_POST_FRONT, 32'hC0DE_0001);
      send_request(mrq_pkg::REQ_POST_BACK, 32'hC0DE_0002);
      send_request(mrq_pkg::REQ_POST_FRONT, 32'hC0DE_0003);
      send_request(mrq_pkg::REQ_PEEK, 32'h0);
      send_request(mrq_pkg::REQ_POP, 32'h0);
      send_request(mrq_pkg::REQ_POP, 32'h0);

      // Directed: oversized capacity, then shrink while words are stored
      wait_idle();
      write_capacity(CAP_MAX_CODE);
      send_request(mrq_pkg::REQ_POST_BACK, 32'h0000_0011);
      send_request(mrq_pkg::REQ_POST_BACK, 32'h0000_0022);
      send_request(mrq_pkg::REQ_POST_BACK, 32'h0000_0033);
      wait_idle();
      write_capacity(5'd2);
      send_request(mrq_pkg::REQ_POST_BACK, 32'h0000_0044);
      send_request(mrq_pkg::REQ_POP, 32'h0);
      send_request(mrq_pkg::REQ_POP, 32'h0);
      send_request(mrq_pkg::REQ_POP, 32'h0);

      // Random phases, each with its own capacity, bias and idling style
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0:       cap = CAP_ZERO;
            1:       cap = CAP_ONE;
            2:       cap = CAP_FULL_DEPTH;
            3:       cap = 5'($urandom_range(17, CAP_MAX_CODE));
            default: cap = 5'($urandom_range(2, 15));
         endcase
         write_capacity(cap);
         case ($urandom_range(0, 2))
            0:       post_pct = 70;
            1:       post_pct = 25;
            default: post_pct = 45;
         endcase
         req_no_gap   = ($urandom_range(0, 3) == 0);
         rsp_no_stall = ($urandom_range(0, 3) == 0);
         phase_len    = $urandom_range(20, 100);
         repeat (phase_len) begin
            kind = random_kind(post_pct);
            // Steer clear of slots that hold no defined word
            if ((kind == mrq_pkg::REQ_POP || kind == mrq_pkg::REQ_PEEK) &&
                !board.read_is_safe())
               kind = mrq_pkg::REQ_FLUSH;
            send_request(kind, random_word());
            sent++;
         end
      end

      wait_idle();
      if (board.pending_results.size() != 0) begin
         $error("%0d results never arrived", board.pending_results.size());
         board.errors++;
      end
      $display("Covered %0d results: pop %0d, post back %0d, post front %0d, peek %0d, flush %0d",
               board.results_checked, board.kind_seen[mrq_pkg::REQ_POP],
               board.kind_seen[mrq_pkg::REQ_POST_BACK],
               board.kind_seen[mrq_pkg::REQ_POST_FRONT],
               board.kind_seen[mrq_pkg::REQ_PEEK],
               board.kind_seen[mrq_pkg::REQ_FLUSH]);
      $display("Full refusals %0d, empty replies %0d, capacity writes %0d",
               board.full_seen, board.empty_seen, cap_writes);
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
